// ===== hdl/crtc_pkg.sv =====
`default_nettype none

package crtc_pkg;

   // register file geometry
   localparam int NUM_REGS  = 25;
   localparam int REG_IDX_W = $clog2(NUM_REGS);

   // cursor divider: one quotient bit per step over a 16-bit cursor address
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // CRTC register indices with side effects
   localparam logic [7:0] CR_HDISP_END  = 8'h01;
   localparam logic [7:0] CR_OVERFLOW   = 8'h07;
   localparam logic [7:0] CR_PRESET_ROW = 8'h08;
   localparam logic [7:0] CR_MAX_SCAN   = 8'h09;
   localparam logic [7:0] CR_START_HI   = 8'h0C;
   localparam logic [7:0] CR_START_LO   = 8'h0D;
   localparam logic [7:0] CR_CURSOR_HI  = 8'h0E;
   localparam logic [7:0] CR_CURSOR_LO  = 8'h0F;
   localparam logic [7:0] CR_VDISP_END  = 8'h12;
   localparam logic [7:0] CR_OFFSET     = 8'h13;
   localparam logic [7:0] CR_MODE_CTRL  = 8'h17;

   typedef enum logic [1:0] {
      OP_WR_INDEX = 2'd0,
      OP_RD_INDEX = 2'd1,
      OP_WR_DATA  = 2'd2,
      OP_RD_DATA  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      NOTE_NONE     = 2'd0,
      NOTE_RESIZE   = 2'd1,
      NOTE_SETTINGS = 2'd2
   } notify_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_SAVE,
      ST_RESPOND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic div_load;
      logic div_step;
      logic div_save;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hdl/crtc_channels.sv =====
`default_nettype none

// access beat: opcode and write byte
interface crtc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] write_data;

   modport source (output valid, output opcode, output write_data, input ready);
   modport sink   (input valid, input opcode, input write_data, output ready);
endinterface

// result beat: read byte, notification and derived display values
interface crtc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic [1:0]  notify;
   logic [15:0] frame_start;
   logic [9:0]  vdisplay_end;
   logic [8:0]  hdisplay_end;
   logic [4:0]  line_skip;
   logic [1:0]  byte_skip;
   logic        line_double;
   logic [3:0]  line_height;
   logic [13:0] cursor_line;
   logic [8:0]  cursor_column;
   logic        cga_active;

   modport source (
      output valid, input ready,
      output read_data, output notify, output frame_start, output vdisplay_end,
      output hdisplay_end, output line_skip, output byte_skip, output line_double,
      output line_height, output cursor_line, output cursor_column, output cga_active
   );
   modport sink (
      input valid, output ready,
      input read_data, input notify, input frame_start, input vdisplay_end,
      input hdisplay_end, input line_skip, input byte_skip, input line_double,
      input line_height, input cursor_line, input cursor_column, input cga_active
   );
endinterface

`default_nettype wire

// ===== hdl/crtc_ctrl.sv =====
`default_nettype none

module crtc_ctrl import crtc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.need_div ? ST_DIV_LOAD : ST_RESPOND;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DIV_SAVE;
            end
         end
         ST_DIV_SAVE: begin
            cmd.div_save = 1'b1;
            state_in     = ST_RESPOND;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/crtc_dpath.sv =====
`default_nettype none

module crtc_dpath import crtc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [1:0]    req_opcode,
   input  logic [7:0]    req_write_data,
   output logic [7:0]    read_data,
   output logic [1:0]    notify,
   output logic [15:0]   frame_start,
   output logic [9:0]    vdisplay_end,
   output logic [8:0]    hdisplay_end,
   output logic [4:0]    line_skip,
   output logic [1:0]    byte_skip,
   output logic          line_double,
   output logic [3:0]    line_height,
   output logic [13:0]   cursor_line,
   output logic [8:0]    cursor_column,
   output logic          cga_active
);

   // captured beat
   opcode_type           op_ff, op_in;
   logic [7:0]           wd_ff, wd_in;

   // architectural state
   logic [7:0]           index_ff, index_in;
   logic [7:0]           regs_ff [NUM_REGS];
   logic [7:0]           regs_in [NUM_REGS];
   logic [15:0]          start_ff, start_in;
   logic [9:0]           vend_ff, vend_in;
   logic [8:0]           hend_ff, hend_in;
   logic [6:0]           skip_ff, skip_in;
   logic [4:0]           line_ff, line_in;
   logic [13:0]          row_ff, row_in;
   logic [8:0]           col_ff, col_in;
   logic                 cga_ff, cga_in;

   // result byte and notification
   logic [7:0]           rd_ff, rd_in;
   notify_type           note_ff, note_in;

   // cursor divider
   logic [9:0]           rem_ff, rem_in;
   logic [15:0]          quo_ff, quo_in;
   logic [8:0]           divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic                 idx_ok;
   logic [REG_IDX_W-1:0] idx;
   logic [7:0]           offset;
   logic [9:0]           trial;
   logic                 trial_ge;

   assign idx_ok = index_ff < 8'(NUM_REGS);
   assign idx    = index_ff[REG_IDX_W-1:0];
   assign offset = regs_ff[REG_IDX_W'(CR_OFFSET)];

   // restoring division step
   assign trial    = {rem_ff[8:0], quo_ff[15]};
   assign trial_ge = trial >= {1'b0, divisor_ff};

   // cursor recomputed only on cursor address writes with an offset of two or more
   assign status.need_div = (op_ff == OP_WR_DATA)
                            && ((index_ff == CR_CURSOR_HI) || (index_ff == CR_CURSOR_LO))
                            && (offset >= 8'd2);
   assign status.div_last = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);

   // next-state logic
   always_comb begin
      op_in      = op_ff;
      wd_in      = wd_ff;
      index_in   = index_ff;
      regs_in    = regs_ff;
      start_in   = start_ff;
      vend_in    = vend_ff;
      hend_in    = hend_ff;
      skip_in    = skip_ff;
      line_in    = line_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      cga_in     = cga_ff;
      rd_in      = rd_ff;
      note_in    = note_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;

      // capture beat
      if (cmd.load) begin
         op_in = opcode_type'(req_opcode);
         wd_in = req_write_data;
      end

      // register access and derived values
      if (cmd.exec) begin
         rd_in   = 8'd0;
         note_in = NOTE_NONE;
         unique case (op_ff)
            OP_WR_INDEX: index_in = wd_ff;
            OP_RD_INDEX: rd_in    = index_ff;
            OP_WR_DATA: begin
               if (idx_ok) begin
                  regs_in[idx] = wd_ff;
                  unique case (index_ff)
                     CR_HDISP_END: begin
                        hend_in = 9'(wd_ff) + 9'd1;
                        note_in = NOTE_RESIZE;
                     end
                     CR_OVERFLOW: begin
                        vend_in = {wd_ff[6], wd_ff[1], vend_ff[7:0]};
                        note_in = NOTE_RESIZE;
                     end
                     CR_PRESET_ROW: skip_in = wd_ff[6:0];
                     CR_MAX_SCAN: begin
                        line_in = {wd_ff[7], wd_ff[3:0]};
                        note_in = NOTE_RESIZE;
                     end
                     CR_START_HI: start_in = {wd_ff, start_ff[7:0]};
                     CR_START_LO: start_in = {start_ff[15:8], wd_ff};
                     CR_VDISP_END: begin
                        vend_in = {vend_ff[9:8], wd_ff};
                        note_in = NOTE_RESIZE;
                     end
                     CR_OFFSET: note_in = NOTE_RESIZE;
                     CR_MODE_CTRL: begin
                        cga_in  = ~wd_ff[0];
                        note_in = NOTE_SETTINGS;
                     end
                     default: ;
                  endcase
               end
            end
            OP_RD_DATA: rd_in = idx_ok ? regs_ff[idx] : 8'd0;
            default: ;
         endcase
      end

      // divider load: cursor address over twice the offset
      if (cmd.div_load) begin
         rem_in     = 10'd0;
         quo_in     = {regs_ff[REG_IDX_W'(CR_CURSOR_HI)], regs_ff[REG_IDX_W'(CR_CURSOR_LO)]};
         divisor_in = {offset, 1'b0};
         cnt_in     = '0;
      end

      // one quotient bit a step
      if (cmd.div_step) begin
         rem_in = trial_ge ? (trial - {1'b0, divisor_ff}) : trial;
         quo_in = {quo_ff[14:0], trial_ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
      end

      if (cmd.div_save) begin
         row_in = quo_ff[13:0];
         col_in = rem_ff[8:0];
      end
   end

   // architectural state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 8'd0;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= 8'd0;
         end
         start_ff <= 16'd0;
         vend_ff  <= 10'd0;
         hend_ff  <= 9'd0;
         skip_ff  <= 7'd0;
         line_ff  <= 5'd0;
         row_ff   <= 14'd0;
         col_ff   <= 9'd0;
         cga_ff   <= 1'b0;
      end else begin
         index_ff <= index_in;
         regs_ff  <= regs_in;
         start_ff <= start_in;
         vend_ff  <= vend_in;
         hend_ff  <= hend_in;
         skip_ff  <= skip_in;
         line_ff  <= line_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         cga_ff   <= cga_in;
      end
   end

   // beat, result and divider payload
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      wd_ff      <= wd_in;
      rd_ff      <= rd_in;
      note_ff    <= note_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
   end

   assign read_data     = rd_ff;
   assign notify        = note_ff;
   assign frame_start   = start_ff;
   assign vdisplay_end  = vend_ff;
   assign hdisplay_end  = hend_ff;
   assign line_skip     = skip_ff[4:0];
   assign byte_skip     = skip_ff[6:5];
   assign line_double   = line_ff[4];
   assign line_height   = line_ff[3:0];
   assign cursor_line   = row_ff;
   assign cursor_column = col_ff;
   assign cga_active    = cga_ff;

endmodule

`default_nettype wire

// ===== hdl/vga_crtc_register_file.sv =====
// VGA CRT controller register file behind an index port and a data port. One
// access beat in gives one result beat out, carrying the read byte, the
// notification and the current derived display values. Accesses are handled
// one at a time: a plain access passes through accept, execute and present.
// A data write to the cursor address registers while the offset register is 2
// or more adds divider load, run and save steps before present: the cursor
// row and column come from a restoring divider that yields one quotient bit
// per cycle over the 16-bit cursor address.
`default_nettype none

module vga_crtc_register_file import crtc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   crtc_req_if.sink  req_bus,
   crtc_rsp_if.source rsp_bus
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   crtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, derived values and cursor divider
   crtc_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_bus.opcode),
      .req_write_data (req_bus.write_data),
      .read_data      (rsp_bus.read_data),
      .notify         (rsp_bus.notify),
      .frame_start    (rsp_bus.frame_start),
      .vdisplay_end   (rsp_bus.vdisplay_end),
      .hdisplay_end   (rsp_bus.hdisplay_end),
      .line_skip      (rsp_bus.line_skip),
      .byte_skip      (rsp_bus.byte_skip),
      .line_double    (rsp_bus.line_double),
      .line_height    (rsp_bus.line_height),
      .cursor_line    (rsp_bus.cursor_line),
      .cursor_column  (rsp_bus.cursor_column),
      .cga_active     (rsp_bus.cga_active)
   );

endmodule

`default_nettype wire

// ===== hdl/crtc_checker.sv =====
`default_nettype none

module crtc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_read_data,
   input logic [1:0]  rsp_notify,
   input logic [15:0] rsp_frame_start
);

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_notify) && $stable(rsp_frame_start))
      else $error("result beat changed while stalled");

   // one access in flight: never open for input while a result is shown
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input open while result pending");

   // an accepted access passes through execute before its result is shown
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("result shown too early");

   // after a result is taken the block is ready again
   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
      else $error("not ready after result taken");

   // notification code 3 is never produced
   a_notify_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_notify != 2'd3)
      else $error("invalid notification code");

endmodule

bind vga_crtc_register_file crtc_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_read_data   (rsp_bus.read_data),
   .rsp_notify      (rsp_bus.notify),
   .rsp_frame_start (rsp_bus.frame_start)
);

`default_nettype wire
